// ===== design/rrsel_pkg.sv =====
// shared types and constants for the endpoint selector
package rrsel_pkg;

    localparam int MAX_ENDPOINTS = 16;
    localparam int ENDPOINT_BITS = 48;
    localparam int IDX_W         = $clog2(MAX_ENDPOINTS);
    localparam int CNT_W         = $clog2(MAX_ENDPOINTS + 1);
    localparam int OFS_W         = 33;

    localparam logic [2:0] CMD_SELECT = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_DEAD   = 3'd2;
    localparam logic [2:0] CMD_ALIVE  = 3'd3;
    localparam logic [2:0] CMD_REMOVE = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_SEL_RD,
        S_SEL_WAIT,
        S_APPEND,
        S_PURGE_A,
        S_PURGE_D,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [OFS_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
    } t_div_req;

endpackage

// ===== design/rrsel_ram.sv =====
// generic simple dual-port ram (one write port, one read port) with registered read
module rrsel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/rrsel_mod.sv =====
// bit-serial remainder of a 33-bit offset by a list length
module rrsel_mod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rrsel_pkg::t_div_req       i_req,
    output logic                      o_done,
    output logic [rrsel_pkg::IDX_W-1:0] o_rem
);
    localparam int CW = rrsel_pkg::CNT_W;
    localparam int OW = rrsel_pkg::OFS_W;
    localparam int SW = $clog2(OW + 1);

    logic [OW-1:0] r_num, n_num;
    logic [CW-1:0] r_rem, n_rem;
    logic [CW-1:0] r_den;
    logic [SW-1:0] r_left, n_left;
    logic          r_busy, n_busy;
    logic [CW:0]   shifted;

    always_comb begin
        shifted = {r_rem, r_num[OW-1]};
        n_num   = r_num;
        n_rem   = r_rem;
        n_left  = r_left;
        n_busy  = r_busy;
        if (i_req.start) begin
            n_num  = i_req.dividend;
            n_rem  = '0;
            n_left = SW'(OW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[OW-2:0], 1'b0};
            if (shifted >= {1'b0, r_den}) begin
                n_rem = CW'(shifted - {1'b0, r_den});
            end else begin
                n_rem = CW'(shifted);
            end
            n_left = r_left - SW'(1);
            if (r_left == SW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else begin
            r_busy <= n_busy;
            r_left <= n_left;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.divisor;
        end
    end

    assign o_done = r_busy && (r_left == SW'(1));
    assign o_rem  = rrsel_pkg::IDX_W'(n_rem);

`ifndef SYNTHESIS
    a_rem_lt_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ({1'b0, n_rem} < {1'b0, r_den}))
        else $error("remainder not below divisor");
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy)
        else $error("divider not busy after start");
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !r_busy)
        else $error("divider busy after done");
`endif
endmodule

// ===== design/rr_endpoint_selector_unit.sv =====
// top level: round-robin endpoint selector with dead-list fallback
// select runs a serial 33-step remainder, then a ram read; add appends one entry;
// mark and remove read, compact and write back the list the entry leaves (remove: both
// ram lists) one entry a cycle; clear empties both. one command at a time, busy while working.
// reset (synchronous, active low) empties both lists and clears the counter; list ram
// contents are not cleared. results cannot be stalled by the receiver.
module rr_endpoint_selector_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [47:0] i_endpoint_id,
    input  logic [7:0]  i_retry_number,
    input  logic [31:0] i_retry_ticket,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [47:0] o_chosen_endpoint,
    output logic [31:0] o_ticket,
    output logic        o_from_dead_list
);
    localparam int IW = rrsel_pkg::IDX_W;
    localparam int CW = rrsel_pkg::CNT_W;
    localparam int EW = rrsel_pkg::ENDPOINT_BITS;

    rrsel_pkg::t_state r_state, n_state;

    logic [2:0]    r_cmd;
    logic [EW-1:0] r_id;
    logic [31:0]   r_rr, n_rr;
    logic [31:0]   r_tick, n_tick;
    logic [7:0]    r_retry;
    logic [CW-1:0] r_acnt, n_acnt, r_dcnt, n_dcnt;
    logic [CW-1:0] r_rd, n_rd, r_wr, n_wr;
    logic          r_rvld, n_rvld;
    logic          r_useded, n_useded;
    logic [1:0]    r_status, n_status;

    logic          a_we, d_we;
    logic [IW-1:0] a_waddr, d_waddr, a_raddr, d_raddr;
    logic [EW-1:0] a_wdata, d_wdata, a_rdata, d_rdata;

    rrsel_pkg::t_div_req div_req;
    logic                div_done;
    logic [IW-1:0]       div_rem;
    logic [IW-1:0]       r_pick;

    logic          out_valid;
    logic [1:0]    out_status;
    logic [47:0]   out_ep;
    logic [31:0]   out_tick;
    logic          out_dead;

    rrsel_ram #(.WIDTH(EW), .DEPTH(rrsel_pkg::MAX_ENDPOINTS)) u_alive (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_raddr(a_raddr), .o_rdata(a_rdata)
    );
    rrsel_ram #(.WIDTH(EW), .DEPTH(rrsel_pkg::MAX_ENDPOINTS)) u_dead (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_waddr), .i_wdata(d_wdata),
        .i_raddr(d_raddr), .o_rdata(d_rdata)
    );
    rrsel_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req),
        .o_done(div_done), .o_rem(div_rem)
    );

    logic accept;
    assign accept = start && !busy;
    assign busy   = (r_state != rrsel_pkg::S_IDLE);

    logic [rrsel_pkg::OFS_W-1:0] offset;
    assign offset = {1'b0, r_tick} + rrsel_pkg::OFS_W'(r_retry);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rrsel_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        rrsel_pkg::CMD_SELECT: n_state = rrsel_pkg::S_DIV;
                        rrsel_pkg::CMD_ADD,
                        rrsel_pkg::CMD_DEAD,
                        rrsel_pkg::CMD_ALIVE: n_state = rrsel_pkg::S_APPEND;
                        rrsel_pkg::CMD_REMOVE: n_state = rrsel_pkg::S_PURGE_A;
                        default: n_state = rrsel_pkg::S_DONE;
                    endcase
                end
            end
            rrsel_pkg::S_DIV: begin
                if (r_acnt == '0 && r_dcnt == '0) begin
                    n_state = rrsel_pkg::S_DONE;
                end else if (div_done) begin
                    n_state = rrsel_pkg::S_SEL_RD;
                end
            end
            rrsel_pkg::S_SEL_RD: n_state = rrsel_pkg::S_SEL_WAIT;
            rrsel_pkg::S_SEL_WAIT: n_state = rrsel_pkg::S_DONE;
            rrsel_pkg::S_APPEND: begin
                case (r_cmd)
                    rrsel_pkg::CMD_DEAD: n_state = rrsel_pkg::S_PURGE_A;
                    rrsel_pkg::CMD_ALIVE: n_state = rrsel_pkg::S_PURGE_D;
                    default: n_state = rrsel_pkg::S_DONE;
                endcase
            end
            rrsel_pkg::S_PURGE_A: begin
                if (r_rd == r_acnt && !r_rvld) begin
                    n_state = (r_cmd == rrsel_pkg::CMD_REMOVE) ?
                              rrsel_pkg::S_PURGE_D : rrsel_pkg::S_DONE;
                end
            end
            rrsel_pkg::S_PURGE_D: begin
                if (r_rd == r_dcnt && !r_rvld) begin
                    n_state = rrsel_pkg::S_DONE;
                end
            end
            rrsel_pkg::S_DONE: n_state = rrsel_pkg::S_IDLE;
            default: n_state = rrsel_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_rr     = r_rr;
        n_tick   = r_tick;
        n_acnt   = r_acnt;
        n_dcnt   = r_dcnt;
        n_rd     = r_rd;
        n_wr     = r_wr;
        n_rvld   = 1'b0;
        n_useded = r_useded;
        n_status = r_status;
        a_we     = 1'b0;
        d_we     = 1'b0;
        a_waddr  = IW'(r_wr);
        d_waddr  = IW'(r_wr);
        a_wdata  = r_id;
        d_wdata  = r_id;
        a_raddr  = IW'(r_rd);
        d_raddr  = IW'(r_rd);
        div_req.start    = 1'b0;
        div_req.dividend = offset;
        div_req.divisor  = (r_acnt != '0) ? r_acnt : r_dcnt;
        out_valid  = 1'b0;
        out_status = r_status;
        out_ep     = '0;
        out_tick   = '0;
        out_dead   = 1'b0;
        case (r_state)
            rrsel_pkg::S_IDLE: begin
                n_status = rrsel_pkg::ST_OK;
                n_rd     = '0;
                n_wr     = '0;
                n_useded = 1'b0;
                if (accept) begin
                    case (i_cmd)
                        rrsel_pkg::CMD_SELECT: begin
                            if (i_retry_number == 8'd0) begin
                                n_rr   = r_rr + 32'd1;
                                n_tick = r_rr + 32'd1;
                            end else begin
                                n_tick = i_retry_ticket;
                            end
                        end
                        rrsel_pkg::CMD_CLEAR: begin
                            n_acnt = '0;
                            n_dcnt = '0;
                        end
                        default: n_tick = r_tick;
                    endcase
                end
            end
            rrsel_pkg::S_DIV: begin
                div_req.start = (r_rd == '0) && (r_acnt != '0 || r_dcnt != '0);
                n_rd = CW'(1);
                n_useded = (r_acnt == '0);
                if (r_acnt == '0 && r_dcnt == '0) begin
                    n_status = rrsel_pkg::ST_NONE;
                end
            end
            rrsel_pkg::S_SEL_RD: begin
                a_raddr = r_pick;
                d_raddr = r_pick;
            end
            rrsel_pkg::S_SEL_WAIT: begin
                a_raddr = r_pick;
                d_raddr = r_pick;
            end
            rrsel_pkg::S_APPEND: begin
                if (r_cmd == rrsel_pkg::CMD_DEAD) begin
                    if (r_dcnt == CW'(rrsel_pkg::MAX_ENDPOINTS)) begin
                        n_status = rrsel_pkg::ST_FULL;
                    end else begin
                        d_we    = 1'b1;
                        d_waddr = IW'(r_dcnt);
                        n_dcnt  = r_dcnt + CW'(1);
                    end
                end else begin
                    if (r_acnt == CW'(rrsel_pkg::MAX_ENDPOINTS)) begin
                        n_status = rrsel_pkg::ST_FULL;
                    end else begin
                        a_we    = 1'b1;
                        a_waddr = IW'(r_acnt);
                        n_acnt  = r_acnt + CW'(1);
                    end
                end
            end
            rrsel_pkg::S_PURGE_A: begin
                if (r_rd != r_acnt) begin
                    n_rd   = r_rd + CW'(1);
                    n_rvld = 1'b1;
                end
                if (r_rvld && a_rdata != r_id) begin
                    a_we    = 1'b1;
                    a_wdata = a_rdata;
                    n_wr    = r_wr + CW'(1);
                end
                if (r_rd == r_acnt && !r_rvld) begin
                    n_acnt = r_wr;
                    n_rd   = '0;
                    n_wr   = '0;
                end
            end
            rrsel_pkg::S_PURGE_D: begin
                if (r_rd != r_dcnt) begin
                    n_rd   = r_rd + CW'(1);
                    n_rvld = 1'b1;
                end
                if (r_rvld && d_rdata != r_id) begin
                    d_we    = 1'b1;
                    d_wdata = d_rdata;
                    n_wr    = r_wr + CW'(1);
                end
                if (r_rd == r_dcnt && !r_rvld) begin
                    n_dcnt = r_wr;
                    n_rd   = '0;
                    n_wr   = '0;
                end
            end
            rrsel_pkg::S_DONE: begin
                out_valid = 1'b1;
                if (r_cmd == rrsel_pkg::CMD_SELECT) begin
                    out_tick = r_tick;
                    if (r_status == rrsel_pkg::ST_OK) begin
                        out_ep   = 48'(r_useded ? d_rdata : a_rdata);
                        out_dead = r_useded;
                    end
                end
            end
            default: begin
                n_rd = r_rd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rrsel_pkg::S_IDLE;
            r_rr     <= '0;
            r_acnt   <= '0;
            r_dcnt   <= '0;
            r_rd     <= '0;
            r_wr     <= '0;
            r_rvld   <= 1'b0;
            r_useded <= 1'b0;
            r_status <= rrsel_pkg::ST_OK;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rr     <= n_rr;
            r_acnt   <= n_acnt;
            r_dcnt   <= n_dcnt;
            r_rd     <= n_rd;
            r_wr     <= n_wr;
            r_rvld   <= n_rvld;
            r_useded <= n_useded;
            r_status <= n_status;
            o_valid  <= out_valid;
        end
        r_tick <= n_tick;
        if (accept) begin
            r_cmd   <= i_cmd;
            r_id    <= EW'(i_endpoint_id);
            r_retry <= i_retry_number;
        end
        if (div_done) begin
            r_pick <= div_rem;
        end
        o_status          <= out_status;
        o_chosen_endpoint <= out_ep;
        o_ticket          <= out_tick;
        o_from_dead_list  <= out_dead;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acnt <= CW'(rrsel_pkg::MAX_ENDPOINTS)) && (r_dcnt <= CW'(rrsel_pkg::MAX_ENDPOINTS)))
        else $error("list count out of range");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result while still busy");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted word did not start work");
    a_wr_le_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrsel_pkg::S_PURGE_A || r_state == rrsel_pkg::S_PURGE_D) |-> r_wr <= r_rd)
        else $error("compaction write passed read");
`endif
endmodule

// ===== tb/rr_endpoint_selector_unit_chk.sv =====
// checker: predicts endpoint selector results and compares them with the block outputs
module rr_endpoint_selector_unit_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [2:0]  i_cmd,
    input  logic [47:0] i_endpoint_id,
    input  logic [7:0]  i_retry_number,
    input  logic [31:0] i_retry_ticket,
    input  logic        i_valid,
    input  logic [1:0]  i_status,
    input  logic [47:0] i_chosen_endpoint,
    input  logic [31:0] i_ticket,
    input  logic        i_from_dead_list,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_alive_len,
    output int          o_dead_len
);

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] chosen;
        logic [31:0] ticket;
        logic        from_dead;
    } t_word;

    t_word       want_q[$];
    logic [31:0] rr_ctr;
    logic [47:0] alive_list[$];
    logic [47:0] dead_list[$];

    assign o_pending   = want_q.size();
    assign o_alive_len = alive_list.size();
    assign o_dead_len  = dead_list.size();

    function automatic void purge(ref logic [47:0] lst[$], input logic [47:0] id);
        logic [47:0] kept[$];
        foreach (lst[k]) if (lst[k] != id) kept = {kept, lst[k]};
        lst = kept;
    endfunction

    task automatic predict_selection(input logic [2:0] cmd, input logic [47:0] id,
                                     input logic [7:0] retry, input logic [31:0] tin);
        t_word       w;
        logic [32:0] ofs;
        w = '0;
        case (cmd)
            rrsel_pkg::CMD_SELECT: begin
                if (retry == 8'd0) begin
                    rr_ctr = rr_ctr + 32'd1;
                    w.ticket = rr_ctr;
                end else begin
                    w.ticket = tin;
                end
                ofs = {1'b0, w.ticket} + 33'(retry);
                if (alive_list.size() > 0) begin
                    w.chosen = alive_list[ofs % alive_list.size()];
                end else if (dead_list.size() > 0) begin
                    w.chosen = dead_list[ofs % dead_list.size()];
                    w.from_dead = 1'b1;
                end else begin
                    w.status = rrsel_pkg::ST_NONE;
                end
            end
            rrsel_pkg::CMD_ADD: begin
                if (alive_list.size() >= rrsel_pkg::MAX_ENDPOINTS) w.status = rrsel_pkg::ST_FULL;
                else alive_list = {alive_list, id};
            end
            rrsel_pkg::CMD_DEAD: begin
                if (dead_list.size() >= rrsel_pkg::MAX_ENDPOINTS) w.status = rrsel_pkg::ST_FULL;
                else dead_list = {dead_list, id};
                purge(alive_list, id);
            end
            rrsel_pkg::CMD_ALIVE: begin
                if (alive_list.size() >= rrsel_pkg::MAX_ENDPOINTS) w.status = rrsel_pkg::ST_FULL;
                else alive_list = {alive_list, id};
                purge(dead_list, id);
            end
            rrsel_pkg::CMD_REMOVE: begin
                purge(alive_list, id);
                purge(dead_list, id);
            end
            rrsel_pkg::CMD_CLEAR: begin
                alive_list.delete();
                dead_list.delete();
            end
            default: ;
        endcase
        want_q = {want_q, w};
    endtask

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            rr_ctr = '0;
            alive_list.delete();
            dead_list.delete();
            want_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_valid) begin
                if (want_q.size() == 0) begin
                    $error("result word with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    w = want_q.pop_front();
                    if (i_status !== w.status) $error("status exp %0d got %0d", w.status, i_status);
                    if (i_chosen_endpoint !== w.chosen)
                        $error("chosen_endpoint exp %h got %h", w.chosen, i_chosen_endpoint);
                    if (i_ticket !== w.ticket) $error("ticket exp %h got %h", w.ticket, i_ticket);
                    if (i_from_dead_list !== w.from_dead)
                        $error("from_dead_list exp %0d got %0d", w.from_dead, i_from_dead_list);
                    if (i_status !== w.status || i_chosen_endpoint !== w.chosen ||
                        i_ticket !== w.ticket || i_from_dead_list !== w.from_dead)
                        o_fail_count <= o_fail_count + 1;
                end
            end
            if (i_start && !i_busy)
                predict_selection(i_cmd, i_endpoint_id, i_retry_number, i_retry_ticket);
        end
    end

endmodule

// ===== tb/rr_endpoint_selector_unit_tb.sv =====
// testbench top: drives endpoint selector commands and reports the verdict
module rr_endpoint_selector_unit_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_cmd = '0;
    logic [47:0] i_endpoint_id = '0;
    logic [7:0]  i_retry_number = '0;
    logic [31:0] i_retry_ticket = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [47:0] o_chosen_endpoint;
    logic [31:0] o_ticket;
    logic        o_from_dead_list;
    int          fail_count, pending, alive_len, dead_len;
    int          n_items;
    logic [47:0] id_pool[8];

    always #10 i_clk = ~i_clk;

    rr_endpoint_selector_unit i_dut (.*);

    rr_endpoint_selector_unit_chk i_chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_cmd, .i_endpoint_id,
        .i_retry_number, .i_retry_ticket, .i_valid(o_valid), .i_status(o_status),
        .i_chosen_endpoint(o_chosen_endpoint), .i_ticket(o_ticket),
        .i_from_dead_list(o_from_dead_list), .o_fail_count(fail_count),
        .o_pending(pending), .o_alive_len(alive_len), .o_dead_len(dead_len)
    );

    task automatic issue(input logic [2:0] cmd, input logic [47:0] id,
                         input logic [7:0] retry, input logic [31:0] tin);
        i_cmd          <= cmd;
        i_endpoint_id  <= id;
        i_retry_number <= retry;
        i_retry_ticket <= tin;
        start          <= 1'b1;
        do @(posedge i_clk); while (busy);
        n_items++;
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand_id();
        return 48'({$urandom, $urandom});
    endfunction

    task automatic random_word();
        logic [2:0]  cmd;
        logic [47:0] id;
        logic [7:0]  retry;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 40) cmd = rrsel_pkg::CMD_SELECT;
        else if (r < 60) cmd = rrsel_pkg::CMD_ADD;
        else if (r < 72) cmd = rrsel_pkg::CMD_DEAD;
        else if (r < 84) cmd = rrsel_pkg::CMD_ALIVE;
        else if (r < 94) cmd = rrsel_pkg::CMD_REMOVE;
        else if (r < 97) cmd = rrsel_pkg::CMD_CLEAR;
        else cmd = 3'($urandom_range(6, 7));
        id = ($urandom_range(0, 9) == 0) ? rand_id() : id_pool[$urandom_range(0, 7)];
        retry = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
        issue(cmd, id, retry, $urandom);
    endtask

    initial begin
        n_items = 0;
        foreach (id_pool[k]) id_pool[k] = rand_id();
        id_pool[0] = '0;
        id_pool[1] = 48'hFFFF_FFFF_FFFF;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty select, fill past full, fallback, retries, purge, unknown
        issue(rrsel_pkg::CMD_SELECT, '0, 8'd0, '0);
        issue(rrsel_pkg::CMD_SELECT, '0, 8'd255, 32'hFFFF_FFFF);
        for (int k = 0; k < 17; k++)
            issue(rrsel_pkg::CMD_ADD, (k % 2) ? id_pool[1] : 48'(k), 8'd0, '0);
        issue(rrsel_pkg::CMD_SELECT, '0, 8'd7, 32'hFFFF_FFFF);
        issue(rrsel_pkg::CMD_DEAD, id_pool[1], 8'd0, '0);
        issue(rrsel_pkg::CMD_REMOVE, 48'd0, 8'd0, '0);
        issue(rrsel_pkg::CMD_CLEAR, '0, 8'd0, '0);
        issue(rrsel_pkg::CMD_DEAD, id_pool[1], 8'd0, '0);
        issue(rrsel_pkg::CMD_SELECT, '0, 8'd0, '0);
        issue(rrsel_pkg::CMD_ALIVE, id_pool[1], 8'd0, '0);
        issue(rrsel_pkg::CMD_SELECT, '0, 8'd3, 32'h8000_0000);
        issue(3'd6, id_pool[1], 8'd1, 32'h1);
        issue(3'd7, '0, 8'd0, '0);
        pause(0);
        wait (pending == 0);
        @(posedge i_clk);
        while (n_items < 1775) begin
            int burst;
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) random_word();
            if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 45));
            if (n_items > 900 && n_items < 950) begin
                start <= 1'b0;
                wait (pending == 0);
                @(posedge i_clk);
            end
        end
        start <= 1'b0;
        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        $display("ran %0d command words: selects with retries, list fill, moves, purges",
                 n_items);
        $display("final lists: %0d alive, %0d dead", alive_len, dead_len);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

endmodule
